// File: rtl/ir_pulse_width_transmitter_core_assert.svh
// assertion macros for the ir pulse width transmitter
// no dependencies; included by the top level after its package import
`ifndef IR_PULSE_WIDTH_TRANSMITTER_CORE_ASSERT_SVH
`define IR_PULSE_WIDTH_TRANSMITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// implication in the same cycle
`define IRPWT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpwt assertion failed");
// implication in the next cycle
`define IRPWT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irpwt assertion failed");
`else
`define IRPWT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define IRPWT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/irpwt_pkg.sv
// shared types and constants of the ir pulse width transmitter
// no dependencies
`default_nettype none
package irpwt_pkg;

  localparam int CODE_BITS = 12;
  localparam int BITS_W    = $clog2(CODE_BITS + 1);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_CARRIER_HIGH = 3'd0,
    REG_CARRIER_LOW  = 3'd1,
    REG_ZERO_MARK    = 3'd2,
    REG_ONE_MARK     = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5,
    REG_FRAME_GAP    = 3'd6,
    REG_NONE         = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_MARK_HIGH = 5'b00010,
    PH_MARK_LOW  = 5'b00100,
    PH_SPACE     = 5'b01000,
    PH_GAP       = 5'b10000
  } phase_t;

  typedef struct packed {
    logic led_drive;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/ir_pulse_width_transmitter_core.sv
// ir remote pulse width transmitter: frame sequencer, config registers, output skid
// depends on irpwt_pkg and ir_pulse_width_transmitter_core_assert.svh
//
// channel   dir  handshake            payload
// input     in   in_valid / in_stall   action, code
// result    out  out_valid / out_stall led_drive, busy_res, frame_done, rejected
// config    in   apb psel/penable      paddr, pwdata, prdata
//
// one item per cycle while in_stall is low; each result is registered into the result register or skid at accept
// the sequencer state updates in the accept cycle, so back-to-back ticks flow freely
// a two-entry output (result register plus skid) lets input keep being accepted
// after out_stall rises until the skid entry fills; in_stall follows the skid entry
// synchronous reset clears the sequencer and loads the default timing registers
`default_nettype none
module ir_pulse_width_transmitter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [irpwt_pkg::CODE_BITS-1:0] code,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               led_drive,
  output logic                               busy_res,
  output logic                               frame_done,
  output logic                               rejected,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [irpwt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [irpwt_pkg::DATA_W-1:0]  pwdata,
  output logic      [irpwt_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);
  import irpwt_pkg::*;

  // timing registers
  logic [7:0]  carrier_high_ticks;
  logic [7:0]  carrier_low_ticks;
  logic [7:0]  zero_mark_cycles;
  logic [7:0]  one_mark_cycles;
  logic [15:0] zero_space_ticks;
  logic [15:0] one_space_ticks;
  logic [15:0] frame_gap_ticks;

  // sequencer state
  logic [CODE_BITS-1:0] shift_word, shift_word_next;
  logic [BITS_W-1:0]    bits_left, bits_left_next;
  phase_t               phase, phase_next;
  logic [7:0]           cycles_left, cycles_left_next;
  logic [15:0]          tick_count, tick_count_next;
  logic                 current_bit, current_bit_next;

  result_t res_new;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;
  logic    out_take;
  logic    cfg_wr;

  reg_idx_t reg_idx;

  // helpers for the combinational step
  logic [7:0]           high_min1, low_min1;
  logic [15:0]          tc_dec;
  logic [7:0]           cyc_dec;
  logic [BITS_W-1:0]    bits_dec;
  logic [CODE_BITS-1:0] shifted;
  logic [15:0]          space_sel;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_CARRIER_HIGH: prdata = {{(DATA_W-8){1'b0}}, carrier_high_ticks};
      REG_CARRIER_LOW:  prdata = {{(DATA_W-8){1'b0}}, carrier_low_ticks};
      REG_ZERO_MARK:    prdata = {{(DATA_W-8){1'b0}}, zero_mark_cycles};
      REG_ONE_MARK:     prdata = {{(DATA_W-8){1'b0}}, one_mark_cycles};
      REG_ZERO_SPACE:   prdata = {{(DATA_W-16){1'b0}}, zero_space_ticks};
      REG_ONE_SPACE:    prdata = {{(DATA_W-16){1'b0}}, one_space_ticks};
      REG_FRAME_GAP:    prdata = {{(DATA_W-16){1'b0}}, frame_gap_ticks};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_high_ticks <= 8'd13;
      carrier_low_ticks  <= 8'd13;
      zero_mark_cycles   <= 8'd16;
      one_mark_cycles    <= 8'd48;
      zero_space_ticks   <= 16'd600;
      one_space_ticks    <= 16'd210;
      frame_gap_ticks    <= 16'd64000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CARRIER_HIGH: carrier_high_ticks <= pwdata[7:0];
        REG_CARRIER_LOW:  carrier_low_ticks  <= pwdata[7:0];
        REG_ZERO_MARK:    zero_mark_cycles   <= pwdata[7:0];
        REG_ONE_MARK:     one_mark_cycles    <= pwdata[7:0];
        REG_ZERO_SPACE:   zero_space_ticks   <= pwdata[15:0];
        REG_ONE_SPACE:    one_space_ticks    <= pwdata[15:0];
        REG_FRAME_GAP:    frame_gap_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // zero carrier lengths count as one
  assign high_min1 = (carrier_high_ticks == 8'd0) ? 8'd1 : carrier_high_ticks;
  assign low_min1  = (carrier_low_ticks == 8'd0) ? 8'd1 : carrier_low_ticks;
  assign tc_dec    = (tick_count != 16'd0) ? tick_count - 16'd1 : 16'd0;
  assign cyc_dec   = (cycles_left != 8'd0) ? cycles_left - 8'd1 : 8'd0;
  assign bits_dec  = (bits_left != '0) ? bits_left - BITS_W'(1) : '0;
  assign shifted   = {shift_word[CODE_BITS-2:0], 1'b0};
  assign space_sel = current_bit ? one_space_ticks : zero_space_ticks;

  function automatic logic [7:0] mark_len(input logic b, input logic [7:0] one_c,
                                          input logic [7:0] zero_c);
    logic [7:0] v;
    v = b ? one_c : zero_c;
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  always_comb begin
    shift_word_next  = shift_word;
    bits_left_next   = bits_left;
    phase_next       = phase;
    cycles_left_next = cycles_left;
    tick_count_next  = tick_count;
    current_bit_next = current_bit;
    res_new          = '0;
    if (action) begin
      res_new.busy_res = 1'b1;
      if (phase != PH_IDLE) begin
        res_new.rejected = 1'b1;
      end else begin
        shift_word_next  = code;
        bits_left_next   = BITS_W'(CODE_BITS);
        current_bit_next = code[CODE_BITS-1];
        cycles_left_next = mark_len(code[CODE_BITS-1], one_mark_cycles, zero_mark_cycles);
        phase_next       = PH_MARK_HIGH;
        tick_count_next  = {8'd0, high_min1};
      end
    end else if (phase != PH_IDLE) begin
      res_new.busy_res  = 1'b1;
      res_new.led_drive = (phase == PH_MARK_HIGH);
      tick_count_next   = tc_dec;
      if (tc_dec == 16'd0) begin
        // a segment ends; pick the next one
        priority if (phase == PH_MARK_HIGH) begin
          phase_next      = PH_MARK_LOW;
          tick_count_next = {8'd0, low_min1};
        end else if (phase == PH_MARK_LOW && cyc_dec != 8'd0) begin
          cycles_left_next = cyc_dec;
          phase_next       = PH_MARK_HIGH;
          tick_count_next  = {8'd0, high_min1};
        end else if (phase == PH_MARK_LOW && space_sel != 16'd0) begin
          cycles_left_next = cyc_dec;
          phase_next       = PH_SPACE;
          tick_count_next  = space_sel;
        end else if (phase == PH_MARK_LOW || phase == PH_SPACE) begin
          // mark with empty space, or space done: advance to the next bit, or after the last bit go to the gap or idle
          cycles_left_next = (phase == PH_MARK_LOW) ? cyc_dec : cycles_left;
          shift_word_next  = shifted;
          bits_left_next   = bits_dec;
          if (bits_dec != '0) begin
            current_bit_next = shifted[CODE_BITS-1];
            cycles_left_next = mark_len(shifted[CODE_BITS-1], one_mark_cycles,
                                        zero_mark_cycles);
            phase_next       = PH_MARK_HIGH;
            tick_count_next  = {8'd0, high_min1};
          end else if (frame_gap_ticks == 16'd0) begin
            phase_next         = PH_IDLE;
            tick_count_next    = 16'd0;
            res_new.frame_done = 1'b1;
          end else begin
            phase_next      = PH_GAP;
            tick_count_next = frame_gap_ticks;
          end
        end else begin
          phase_next         = PH_IDLE;
          res_new.frame_done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bits_left   <= '0;
      cycles_left <= 8'd0;
      tick_count  <= 16'd0;
      shift_word  <= '0;
      current_bit <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      bits_left   <= bits_left_next;
      cycles_left <= cycles_left_next;
      tick_count  <= tick_count_next;
      shift_word  <= shift_word_next;
      current_bit <= current_bit_next;
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      out_res <= skid_valid ? skid_res : res_new;
    end
    if (accept) begin
      skid_res <= res_new;
    end
  end

  assign led_drive  = out_res.led_drive;
  assign busy_res   = out_res.busy_res;
  assign frame_done = out_res.frame_done;
  assign rejected   = out_res.rejected;

`include "ir_pulse_width_transmitter_core_assert.svh"

  `IRPWT_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `IRPWT_ASSERT_NOW(a_reject_is_busy, clk, rst, out_valid && rejected, busy_res)
  `IRPWT_ASSERT_NOW(a_done_led_off, clk, rst, out_valid && frame_done, busy_res && !led_drive)
  `IRPWT_ASSERT_NEXT(a_send_starts_mark, clk, rst, accept && action && phase == PH_IDLE, phase == PH_MARK_HIGH)

endmodule
`default_nettype wire
